### rtl/delayed_task_queue_unit_assert.svh
// Assertion macros for the delayed task queue unit.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef DELAYED_TASK_QUEUE_UNIT_ASSERT_SVH
`define DELAYED_TASK_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define DTQ_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("dtq assertion failed");

// Next-cycle implication.
`define DTQ_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("dtq assertion failed");

`endif

### rtl/dtq_pkg.sv
// Types and codes shared by the delayed task queue unit.
// No dependencies.
package dtq_pkg;

  typedef enum logic [2:0] {
    FUNC_POST_NOW   = 3'd0,
    FUNC_POST_AT    = 3'd1,
    FUNC_POST_DELAY = 3'd2,
    FUNC_POLL       = 3'd3,
    FUNC_STOP       = 3'd4,
    FUNC_RESTART    = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CMP,
    ST_INS_WR,
    ST_POLL,
    ST_SHIFT
  } state_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] task_tag;
    logic [31:0] time_value;
    logic [31:0] now;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic        task_valid;
    logic [15:0] task_tag_res;
    logic [7:0]  pending_count;
    logic [31:0] drop_count;
    logic        halted;
  } out_t;

endpackage

### rtl/delayed_task_queue_unit.sv
// Delayed task queue: ready FIFO plus a due-time sorted timed store, both in RAM.
// Depends on dtq_pkg, dtq_ram and delayed_task_queue_unit_assert.svh.
// Post now, stop, restart, refusals and halted poll give their result in the cycle after accept.
// Timed post walks down from the end, shifting later-due entries up, then writes the new entry.
// Poll reads slot 0 and shifts the later timed entries down when a due entry leaves. One word at a
// time: busy is low in the result cycle. Reset clears counts, pointers, flags; no RAM clear.
module delayed_task_queue_unit #(
  parameter int FIFO_DEPTH = 64,
  parameter int HEAP_DEPTH = 64,
  parameter int TIME_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  dtq_pkg::in_t   cmd_i,
  output logic           res_valid_o,
  output dtq_pkg::out_t  res_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [7:0]     cfg_data_i
);

  `include "delayed_task_queue_unit_assert.svh"

  localparam int FAW  = $clog2(FIFO_DEPTH);
  localparam int FCW  = $clog2(FIFO_DEPTH + 1);
  localparam int HAW  = $clog2(HEAP_DEPTH);
  localparam int HCW  = $clog2(HEAP_DEPTH + 1);
  localparam int EW   = TIME_WIDTH + 16;
  localparam int SW   = ((FCW > HCW) ? FCW : HCW) + 1;
  localparam int CMPW = (SW > 8) ? SW : 8;

  dtq_pkg::state_e state_q, state_d;
  dtq_pkg::in_t    cmd_q, cmd_d;
  logic [TIME_WIDTH-1:0] due_q, due_d;
  logic [HCW-1:0]  idx_q, idx_d;
  logic [FAW-1:0]  head_q, head_d;
  logic [FCW-1:0]  rc_q, rc_d;
  logic [HCW-1:0]  hc_q, hc_d;
  logic [31:0]     drop_q, drop_d;
  logic            halt_q, halt_d;
  logic [7:0]      max_q;
  logic            res_valid_q, res_valid_d;
  logic            acc_q, acc_d;
  logic            tvalid_q, tvalid_d;
  logic [15:0]     tag_q, tag_d;

  logic            fifo_we;
  logic [FAW-1:0]  fifo_wa, fifo_ra;
  logic [15:0]     fifo_wd, fifo_rd;
  logic            heap_we;
  logic [HAW-1:0]  heap_wa, heap_ra;
  logic [EW-1:0]   heap_wd, heap_rd;

  logic [CMPW-1:0]       total;
  logic                  lim_ok;
  logic [FCW:0]          tail_sum;
  logic [FAW-1:0]        tail;
  logic [FAW-1:0]        head_next;
  logic [47:0]           tval_ext, now_ext, qnow_ext;
  logic [TIME_WIDTH-1:0] tval_t, now_t, qnow_t, rd_due;
  logic [15:0]           rd_tag;
  logic                  due_now;
  logic [31:0]           drop_inc;

  dtq_ram #(.WIDTH(16), .DEPTH(FIFO_DEPTH)) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .waddr_i (fifo_wa),
    .wdata_i (fifo_wd),
    .raddr_i (fifo_ra),
    .rdata_o (fifo_rd)
  );

  dtq_ram #(.WIDTH(EW), .DEPTH(HEAP_DEPTH)) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (heap_we),
    .waddr_i (heap_wa),
    .wdata_i (heap_wd),
    .raddr_i (heap_ra),
    .rdata_o (heap_rd)
  );

  assign total    = CMPW'(rc_q) + CMPW'(hc_q);
  assign lim_ok   = (max_q == 8'd0) || (total < CMPW'(max_q));
  assign tail_sum = (FCW+1)'(head_q) + (FCW+1)'(rc_q);
  assign tail     = (tail_sum >= (FCW+1)'(FIFO_DEPTH)) ?
                    FAW'(tail_sum - (FCW+1)'(FIFO_DEPTH)) : FAW'(tail_sum);
  assign head_next = (head_q == FAW'(FIFO_DEPTH - 1)) ? '0 : head_q + FAW'(1);
  assign tval_ext = {16'd0, cmd_i.time_value};
  assign now_ext  = {16'd0, cmd_i.now};
  assign qnow_ext = {16'd0, cmd_q.now};
  assign tval_t   = tval_ext[TIME_WIDTH-1:0];
  assign now_t    = now_ext[TIME_WIDTH-1:0];
  assign qnow_t   = qnow_ext[TIME_WIDTH-1:0];
  assign rd_due   = heap_rd[EW-1:16];
  assign rd_tag   = heap_rd[15:0];
  assign due_now  = (hc_q != '0) && (rd_due <= qnow_t);
  assign drop_inc = (drop_q == '1) ? drop_q : drop_q + 32'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dtq_pkg::ST_IDLE;
      head_q      <= '0;
      rc_q        <= '0;
      hc_q        <= '0;
      drop_q      <= '0;
      halt_q      <= 1'b0;
      max_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      rc_q        <= rc_d;
      hc_q        <= hc_d;
      drop_q      <= drop_d;
      halt_q      <= halt_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i) begin
        max_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    due_q    <= due_d;
    idx_q    <= idx_d;
    acc_q    <= acc_d;
    tvalid_q <= tvalid_d;
    tag_q    <= tag_d;
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    due_d       = due_q;
    idx_d       = idx_q;
    head_d      = head_q;
    rc_d        = rc_q;
    hc_d        = hc_q;
    drop_d      = drop_q;
    halt_d      = halt_q;
    res_valid_d = 1'b0;
    acc_d       = acc_q;
    tvalid_d    = tvalid_q;
    tag_d       = tag_q;
    fifo_we     = 1'b0;
    fifo_wa     = tail;
    fifo_wd     = cmd_i.task_tag;
    fifo_ra     = head_q;
    heap_we     = 1'b0;
    heap_wa     = idx_q[HAW-1:0];
    heap_wd     = heap_rd;
    heap_ra     = '0;

    case (state_q)
      dtq_pkg::ST_IDLE: begin
        if (start) begin
          cmd_d    = cmd_i;
          acc_d    = 1'b0;
          tvalid_d = 1'b0;
          tag_d    = '0;
          res_valid_d = 1'b1;
          case (cmd_i.func)
            dtq_pkg::FUNC_POST_NOW, dtq_pkg::FUNC_POST_AT, dtq_pkg::FUNC_POST_DELAY: begin
              if (!lim_ok) begin
                drop_d = drop_inc;
              end else if (cmd_i.func == dtq_pkg::FUNC_POST_NOW ||
                           (cmd_i.func == dtq_pkg::FUNC_POST_DELAY && tval_t == '0)) begin
                if (rc_q == FCW'(FIFO_DEPTH)) begin
                  drop_d = drop_inc;
                end else begin
                  fifo_we = 1'b1;
                  rc_d    = rc_q + FCW'(1);
                  acc_d   = 1'b1;
                end
              end else if (hc_q == HCW'(HEAP_DEPTH)) begin
                drop_d = drop_inc;
              end else begin
                // walk down from the end, shifting later-due entries up
                due_d = (cmd_i.func == dtq_pkg::FUNC_POST_AT) ? tval_t : now_t + tval_t;
                idx_d = hc_q;
                res_valid_d = 1'b0;
                if (hc_q == '0) begin
                  state_d = dtq_pkg::ST_INS_WR;
                end else begin
                  heap_ra = HAW'(hc_q - HCW'(1));
                  state_d = dtq_pkg::ST_INS_CMP;
                end
              end
            end
            dtq_pkg::FUNC_POLL: begin
              if (!halt_q) begin
                heap_ra     = '0;
                res_valid_d = 1'b0;
                state_d     = dtq_pkg::ST_POLL;
              end
            end
            dtq_pkg::FUNC_STOP: begin
              if (!halt_q) begin
                halt_d = 1'b1;
                head_d = '0;
                rc_d   = '0;
                hc_d   = '0;
              end
            end
            dtq_pkg::FUNC_RESTART: begin
              halt_d = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      dtq_pkg::ST_INS_CMP: begin
        if (rd_due > due_q) begin
          heap_we = 1'b1;
          idx_d   = idx_q - HCW'(1);
          if (idx_q > HCW'(1)) begin
            heap_ra = HAW'(idx_q - HCW'(2));
          end else begin
            state_d = dtq_pkg::ST_INS_WR;
          end
        end else begin
          state_d = dtq_pkg::ST_INS_WR;
        end
      end
      dtq_pkg::ST_INS_WR: begin
        heap_we     = 1'b1;
        heap_wd     = {due_q, cmd_q.task_tag};
        hc_d        = hc_q + HCW'(1);
        acc_d       = 1'b1;
        res_valid_d = 1'b1;
        state_d     = dtq_pkg::ST_IDLE;
      end
      dtq_pkg::ST_POLL: begin
        if (rc_q != '0) begin
          tag_d    = fifo_rd;
          acc_d    = 1'b1;
          tvalid_d = 1'b1;
          head_d   = head_next;
          if (due_now) begin
            // head leaves first, so the due entry takes the freed tail slot
            fifo_we = 1'b1;
            fifo_wd = rd_tag;
          end else begin
            rc_d = rc_q - FCW'(1);
          end
        end else if (due_now) begin
          tag_d    = rd_tag;
          acc_d    = 1'b1;
          tvalid_d = 1'b1;
        end
        if (due_now && hc_q > HCW'(1)) begin
          idx_d   = HCW'(1);
          heap_ra = HAW'(1);
          state_d = dtq_pkg::ST_SHIFT;
        end else begin
          if (due_now) begin
            hc_d = '0;
          end
          res_valid_d = 1'b1;
          state_d     = dtq_pkg::ST_IDLE;
        end
      end
      dtq_pkg::ST_SHIFT: begin
        heap_we = 1'b1;
        heap_wa = HAW'(idx_q - HCW'(1));
        if (idx_q + HCW'(1) < hc_q) begin
          heap_ra = HAW'(idx_q + HCW'(1));
          idx_d   = idx_q + HCW'(1);
        end else begin
          hc_d        = hc_q - HCW'(1);
          res_valid_d = 1'b1;
          state_d     = dtq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dtq_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy        = (state_q != dtq_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = res_valid_q;

  always_comb begin
    res_o.accepted      = acc_q;
    res_o.task_valid    = tvalid_q;
    res_o.task_tag_res  = tag_q;
    res_o.pending_count = total[7:0];
    res_o.drop_count    = drop_q;
    res_o.halted        = halt_q;
  end

  `DTQ_ASSERT_NXT(a_accept_progress, start && !busy, busy || res_valid_o)
  `DTQ_ASSERT_IMP(a_release_accepted, res_valid_o && res_o.task_valid, res_o.accepted)
  `DTQ_ASSERT_IMP(a_counts_bounded, 1'b1,
                  rc_q <= FCW'(FIFO_DEPTH) && hc_q <= HCW'(HEAP_DEPTH))

endmodule

### rtl/dtq_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module dtq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
